[hdl/nle_pkg.sv]
// Shared types, constants and helper functions for the name entry line editor.
package nle_pkg;

  // Field widths fixed by the edit report format.
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned PROG_W = 3;
  localparam int unsigned BYTE_W = 8;

  // Default append limit and the largest length the length field can carry.
  localparam int unsigned MAX_NAME_LEN_DEFAULT = 31;
  localparam int unsigned LEN_FIELD_MAX        = 31;

  // Keyword length and the special byte values.
  localparam int unsigned       KEYWORD_LEN = 5;
  localparam logic [BYTE_W-1:0] BYTE_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_DEL    = 8'h7F;
  localparam logic [BYTE_W-1:0] PRINT_LO    = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI    = 8'd126;

  // Edit report kinds.
  typedef enum logic [1:0] {
    EDIT_NONE   = 2'd0,
    EDIT_APPEND = 2'd1,
    EDIT_ERASE  = 2'd2,
    EDIT_CLEAR  = 2'd3
  } edit_kind_t;

  // One edit report as held in the result register.
  typedef struct packed {
    edit_kind_t        kind;
    logic [LEN_W-1:0]  position;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  length;
  } edit_t;

  // Letters of the keyword "clear", indexed by match progress.
  function automatic logic [BYTE_W-1:0] keyword_letter(input logic [PROG_W-1:0] idx);
    logic [BYTE_W-1:0] letter;
    case (idx)
      3'd0:    letter = 8'h63;
      3'd1:    letter = 8'h6C;
      3'd2:    letter = 8'h65;
      3'd3:    letter = 8'h61;
      3'd4:    letter = 8'h72;
      default: letter = 8'h00;
    endcase
    return letter;
  endfunction

  // Effective append limit, saturated to what the length field can hold.
  function automatic logic [LEN_W-1:0] len_limit(input int unsigned max_len);
    int unsigned lim;
    lim = (max_len > LEN_FIELD_MAX) ? LEN_FIELD_MAX : max_len;
    return lim[LEN_W-1:0];
  endfunction

endpackage

[hdl/nle_step.sv]
// Combinational edit logic: keyword matching, erase and append for one byte.
module nle_step #(
  parameter int unsigned MAX_NAME_LEN = nle_pkg::MAX_NAME_LEN_DEFAULT
) (
  input  logic [nle_pkg::BYTE_W-1:0] rx_byte,
  input  logic [nle_pkg::LEN_W-1:0]  length,
  input  logic [nle_pkg::PROG_W-1:0] progress,
  output nle_pkg::edit_t             edit,
  output logic [nle_pkg::LEN_W-1:0]  length_next,
  output logic [nle_pkg::PROG_W-1:0] progress_next
);
  import nle_pkg::*;

  localparam logic [LEN_W-1:0] LenLimit = len_limit(MAX_NAME_LEN);

  logic              match;
  logic [PROG_W-1:0] progress_inc;
  logic              is_erase;
  logic              is_print;

  // The byte continues the keyword only while progress is in range.
  assign match        = (progress < PROG_W'(KEYWORD_LEN)) && (rx_byte == keyword_letter(progress));
  assign progress_inc = progress + PROG_W'(1);
  assign is_erase     = (rx_byte == BYTE_BS) || (rx_byte == BYTE_DEL);
  assign is_print     = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);

  // A keyword byte is swallowed; any other byte resets progress and is edited.
  always_comb begin
    edit.kind     = EDIT_NONE;
    edit.position = '0;
    edit.data     = '0;
    length_next   = length;
    progress_next = '0;
    if (match) begin
      if (progress_inc == PROG_W'(KEYWORD_LEN)) begin
        length_next = '0;
        edit.kind   = EDIT_CLEAR;
      end else begin
        progress_next = progress_inc;
      end
    end else if (is_erase) begin
      if (length != '0) begin
        length_next   = length - LEN_W'(1);
        edit.kind     = EDIT_ERASE;
        edit.position = length - LEN_W'(1);
      end
    end else if (is_print && (length < LenLimit)) begin
      length_next   = length + LEN_W'(1);
      edit.kind     = EDIT_APPEND;
      edit.position = length;
      edit.data     = rx_byte;
    end
    edit.length = length_next;
  end

endmodule

[hdl/name_entry_line_editor.sv]
// Top level of the name entry line editor: input register, edit logic, result register.
//
// The editor takes one received byte per word and returns one edit report per byte,
// in order. It sustains one byte per clock cycle while the result side does not stall.
// A byte passes through the input register and then the result register before its report
// can be taken. The name length and keyword progress are updated as a byte moves from
// the input register to the result register, so consecutive bytes see each other's
// effect with no gap. The typed keyword "clear" empties the name; backspace or delete
// erases the last character; printable bytes are appended up to MAX_NAME_LEN
// (at most 31). A stall on the result side holds the result register and then the
// input register before the input is stalled.
module name_entry_line_editor #(
  parameter int unsigned MAX_NAME_LEN = nle_pkg::MAX_NAME_LEN_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [nle_pkg::BYTE_W-1:0] rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 edit_kind,
  output logic [nle_pkg::LEN_W-1:0]  edit_position,
  output logic [nle_pkg::BYTE_W-1:0] edit_char,
  output logic [nle_pkg::LEN_W-1:0]  name_length,
  output logic                       update_screen
);
  import nle_pkg::*;

  localparam logic [LEN_W-1:0] LenLimit = len_limit(MAX_NAME_LEN);

  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  edit_t             res;
  edit_t             step_edit;
  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  length_next;
  logic [PROG_W-1:0] progress;
  logic [PROG_W-1:0] progress_next;

  // The result register moves on when empty or when its word is taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  nle_step #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_step (
    .rx_byte      (in_byte),
    .length       (length),
    .progress     (progress),
    .edit         (step_edit),
    .length_next  (length_next),
    .progress_next(progress_next)
  );

  // Control state and editor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      length    <= '0;
      progress  <= '0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid <= in_full;
      end
      if (advance && in_full) begin
        length   <= length_next;
        progress <= progress_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= rx_byte;
    end
    if (advance && in_full) begin
      res <= step_edit;
    end
  end

  // Result ports.
  assign edit_kind     = res.kind;
  assign edit_position = res.position;
  assign edit_char     = res.data;
  assign name_length   = res.length;
  assign update_screen = (res.kind != EDIT_NONE);

  // Keyword progress never reaches the full keyword length between bytes.
  assert property (@(posedge clk) disable iff (rst) progress < PROG_W'(KEYWORD_LEN))
    else $error("keyword progress out of range");

  // The reported length never exceeds the append limit.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> name_length <= LenLimit)
    else $error("name length above limit");

  // An append grows the name by one past the written index.
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && edit_kind == EDIT_APPEND) |-> name_length == edit_position + LEN_W'(1))
    else $error("append position does not match length");

  // An erase leaves the length equal to the erased index.
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && edit_kind == EDIT_ERASE) |-> name_length == edit_position)
    else $error("erase position does not match length");

endmodule

[tb/tb_name_entry_line_editor.sv]
// Self-checking testbench for the name entry line editor: directed edits, then random editing.
`timescale 1ns / 100ps

module tb_name_entry_line_editor;
  import nle_pkg::*;

  // The block is built with the default append limit.
  localparam int unsigned NAME_MAX    = 31;
  localparam int unsigned NAME_LIMIT  = (NAME_MAX > 31) ? 31 : NAME_MAX;
  localparam int unsigned WORD_LETTERS = 5;
  localparam logic [39:0] CLEAR_WORD  = "clear";
  localparam int          CYCLE_LIMIT = 200000;

  // One expected edit report.
  typedef struct {
    edit_kind_t  kind;
    logic [4:0]  position;
    logic [7:0]  letter;
    logic [4:0]  length;
    logic        update;
  } edit_report_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] edit_kind;
  logic [4:0] edit_position;
  logic [7:0] edit_char;
  logic [4:0] name_length;
  logic       update_screen;

  // Predicted editor state.
  logic [4:0] pred_length;
  logic [2:0] match_count;

  edit_report_t edit_reports_due[$];
  int           errors = 0;
  int           bytes_sent;
  int           cycle_count = 0;
  int           send_idle_pct;
  int           stall_pct;

  name_entry_line_editor #(
    .MAX_NAME_LEN(NAME_MAX)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .edit_kind    (edit_kind),
    .edit_position(edit_position),
    .edit_char    (edit_char),
    .name_length  (name_length),
    .update_screen(update_screen)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up if the run goes on far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("name_entry_line_editor: mismatch");
      $finish;
    end
  end

  // The receiving side stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    errors++;
  endtask

  // Works out the edit report for one byte and advances the predicted state.
  task automatic predict_edit(input logic [7:0] b, output edit_report_t r);
    logic swallowed;
    swallowed  = 1'b0;
    r.kind     = EDIT_NONE;
    r.position = '0;
    r.letter   = '0;
    if (match_count < WORD_LETTERS && b == CLEAR_WORD[39 - 8 * match_count -: 8]) begin
      match_count = match_count + 3'd1;
      swallowed   = 1'b1;
      if (match_count == WORD_LETTERS) begin
        pred_length = '0;
        match_count = '0;
        r.kind      = EDIT_CLEAR;
      end
    end else begin
      match_count = '0;
    end
    // A byte that is not part of the keyword goes on to ordinary editing.
    if (!swallowed) begin
      if (b == BYTE_BS || b == BYTE_DEL) begin
        if (pred_length != 0) begin
          pred_length = pred_length - 5'd1;
          r.kind      = EDIT_ERASE;
          r.position  = pred_length;
        end
      end else if (b >= PRINT_LO && b <= PRINT_HI && pred_length < NAME_LIMIT) begin
        r.kind      = EDIT_APPEND;
        r.position  = pred_length;
        r.letter    = b;
        pred_length = pred_length + 5'd1;
      end
    end
    r.length = pred_length;
    r.update = (r.kind != EDIT_NONE);
  endtask

  // Offers one word to the block, after a random gap, and records its report once accepted.
  task automatic send_byte(input logic [7:0] b);
    edit_report_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_edit(b, r);
    edit_reports_due.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Holds the sender off until every expected report has come back.
  task automatic wait_for_reports;
    in_valid <= 1'b0;
    while (edit_reports_due.size() != 0) @(posedge clk);
  endtask

  // Each report leaving the block is checked against the oldest prediction.
  always @(posedge clk) begin : check_edits
    edit_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (edit_reports_due.size() == 0) begin
        report_mismatch($sformatf("report with none expected: kind %0d length %0d",
                                  edit_kind, name_length));
      end else begin
        want = edit_reports_due.pop_front();
        if (edit_kind !== want.kind)
          report_mismatch($sformatf("edit_kind got %0d, expected %0d", edit_kind, want.kind));
        if (edit_position !== want.position)
          report_mismatch($sformatf("edit_position got %0d, expected %0d",
                                    edit_position, want.position));
        if (edit_char !== want.letter)
          report_mismatch($sformatf("edit_char got %0d, expected %0d", edit_char, want.letter));
        if (name_length !== want.length)
          report_mismatch($sformatf("name_length got %0d, expected %0d",
                                    name_length, want.length));
        if (update_screen !== want.update)
          report_mismatch($sformatf("update_screen got %0d, expected %0d",
                                    update_screen, want.update));
      end
    end
  end

  // Extremes of the byte, every edit kind, and the keyword corner cases.
  task automatic test_directed_cases;
    send_byte(BYTE_BS);                 // erase on an empty name
    send_byte(BYTE_DEL);
    send_byte(8'h00);                   // non-printable and high bytes do nothing
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h1F);
    send_byte(PRINT_LO);                // printable range edges
    send_byte(PRINT_HI);
    send_byte(BYTE_DEL);
    send_text("clear");                 // clear a non-empty name
    send_text("clear");                 // clear an empty name
    send_text("clx");                   // broken keyword: the odd byte is appended
    send_text("ccl");                   // a mismatching 'c' is not rechecked
    send_byte(BYTE_BS);
    wait_for_reports();
  endtask

  // Fills the name past the limit with printable bytes that never start the keyword.
  task automatic test_fill_to_limit;
    logic [7:0] b;
    send_text("clear");
    for (int i = 0; i < NAME_LIMIT + 3; i++) begin
      b = 8'($urandom_range(32, 126));
      if (b == "c") b = "d";
      send_byte(b);
    end
    send_byte(BYTE_BS);
    send_byte(BYTE_DEL);
    wait_for_reports();
  endtask

  // Random editing: keyword attempts, bursts of typing and erasing, and stray bytes.
  task automatic test_random_editing(input int idle_pct, input int stall_odds, input int count);
    int first;
    int pick;
    int run;
    first         = bytes_sent;
    send_idle_pct = idle_pct;
    stall_pct     = stall_odds;
    while (bytes_sent - first < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_text("clear");
      end else if (pick < 24) begin
        run = $urandom_range(1, 4);
        for (int i = 0; i < run; i++) send_byte(CLEAR_WORD[39 - 8 * i -: 8]);
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 60) begin
        run = $urandom_range(1, 12);
        for (int i = 0; i < run; i++) send_byte(8'($urandom_range(32, 126)));
      end else if (pick < 75) begin
        run = $urandom_range(1, 4);
        for (int i = 0; i < run; i++) send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
      end else if (pick < 77) begin
        wait_for_reports();
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    wait_for_reports();
  endtask

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    rx_byte          = '0;
    pred_length      = '0;
    match_count      = '0;
    bytes_sent       = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_fill_to_limit();
    test_random_editing(0, 0, 430);
    test_random_editing(52, 0, 430);
    test_random_editing(0, 52, 430);
    test_random_editing(33, 33, 430);

    // Let the pipeline settle before the verdict.
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("name_entry_line_editor: match");
    end else begin
      $display("name_entry_line_editor: mismatch");
    end
    $finish;
  end

endmodule
